FILE: src/ddpl_pkg.sv
// Shared types and constants for the drive distance PID loop.
`timescale 1ns / 1ps

package ddpl_pkg;

  localparam int TARGET_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 11;
  localparam int BAND_W      = 12;
  localparam int ERR_W       = 25;
  localparam int INT_W       = 12;
  localparam int CMD_W       = 15;
  localparam int ACC_W       = 44;
  localparam int ACC_LIMIT   = 409600;
  localparam int CMD_SHIFT   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1600);
  localparam logic [BAND_W-1:0]  BAND_RESET  = BAND_W'(16);

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_INT_LIM  = 3'd4,
    REG_DONE_BND = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic [LIMIT_W-1:0]         int_limit;
    logic [BAND_W-1:0]          done_band;
  } cfg_t;

  typedef struct packed {
    logic                    restart;
    logic signed [ERR_W-1:0] err;
  } q_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/ddpl_regs.sv
// APB register file holding target, gains, integral limit and done band.
`timescale 1ns / 1ps

module ddpl_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ddpl_pkg::PADDR_W-1:0]   paddr,
  input  logic [ddpl_pkg::PDATA_W-1:0]   pwdata,
  output logic [ddpl_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output ddpl_pkg::cfg_t                 cfg_o
);
  import ddpl_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= '0;
      cfg_q.gain_p    <= '0;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      cfg_q.int_limit <= LIMIT_RESET;
      cfg_q.done_band <= BAND_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET:   cfg_q.target    <= pwdata[TARGET_W-1:0];
        REG_GAIN_P:   cfg_q.gain_p    <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:   cfg_q.gain_i    <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:   cfg_q.gain_d    <= pwdata[GAIN_W-1:0];
        REG_INT_LIM:  cfg_q.int_limit <= pwdata[LIMIT_W-1:0];
        REG_DONE_BND: cfg_q.done_band <= pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET:   prdata = PDATA_W'(unsigned'(cfg_q.target));
      REG_GAIN_P:   prdata = PDATA_W'(unsigned'(cfg_q.gain_p));
      REG_GAIN_I:   prdata = PDATA_W'(unsigned'(cfg_q.gain_i));
      REG_GAIN_D:   prdata = PDATA_W'(unsigned'(cfg_q.gain_d));
      REG_INT_LIM:  prdata = PDATA_W'(cfg_q.int_limit);
      REG_DONE_BND: prdata = PDATA_W'(cfg_q.done_band);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: src/ddpl_front.sv
// Front pipeline: encoder average by six and position error per word.
`timescale 1ns / 1ps

module ddpl_front #(
  parameter int POSITION_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ddpl_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  input  logic signed [POSITION_BITS-1:0] left_front_pos_i,
  input  logic signed [POSITION_BITS-1:0] left_mid_pos_i,
  input  logic signed [POSITION_BITS-1:0] left_back_pos_i,
  input  logic signed [POSITION_BITS-1:0] right_front_pos_i,
  input  logic signed [POSITION_BITS-1:0] right_mid_pos_i,
  input  logic signed [POSITION_BITS-1:0] right_back_pos_i,
  output logic                            word_valid_o,
  output ddpl_pkg::q_word_t               word_o,
  input  logic                            full_i
);
  import ddpl_pkg::*;

  localparam int P      = POSITION_BITS;
  localparam int TW     = P + 2;
  localparam int SW     = P + 3;
  localparam int HW     = P + 1;
  localparam int NIB    = (HW + 3) / 4;
  localparam int NB     = 4 * NIB;
  localparam int DIV_ST = (NIB + 3) / 4;
  localparam int DW     = ((P > TARGET_W) ? P : TARGET_W) + 2;

  localparam logic signed [DW-1:0] E_MAX = DW'((1 << (ERR_W - 1)) - 1);
  localparam logic signed [DW-1:0] E_MIN = ~E_MAX;

  function automatic logic [5:0] div3_step(input logic [1:0] r, input logic [3:0] d);
    logic [5:0]  v;
    logic [11:0] m;
    logic [3:0]  q;
    logic [5:0]  rm;
    v  = {r, d};
    m  = 12'(v) * 12'd43;
    q  = m[10:7];
    rm = v - 6'(q) * 6'd3;
    return {q, rm[1:0]};
  endfunction

  logic              en;
  logic signed [TW-1:0] tl_q, tr_q;
  logic              rs1_q, v1_q;
  logic signed [SW-1:0] sum6;
  logic [SW-1:0]     mag;

  logic [NB-1:0]     dw_q [DIV_ST+1];
  logic [1:0]        dr_q [DIV_ST+1];
  logic              dneg_q [DIV_ST+1];
  logic              drs_q [DIV_ST+1];
  logic              dv_q [DIV_ST+1];
  logic [NB-1:0]     dw_d [DIV_ST+1];
  logic [1:0]        dr_d [DIV_ST+1];

  logic [P-1:0]      quot;
  logic signed [DW-1:0] qx, avg, diff;
  logic signed [ERR_W-1:0] err_c;
  q_word_t           word_q;
  logic              wv_q;

  assign en           = !wv_q || !full_i;
  assign in_ready_o   = en;
  assign word_valid_o = wv_q;
  assign word_o       = word_q;

  assign sum6 = SW'(tl_q) + SW'(tr_q);
  assign mag  = sum6[SW-1] ? unsigned'(-sum6) : unsigned'(sum6);

  always_comb begin
    logic [NB-1:0] w;
    logic [1:0]    r;
    logic [5:0]    st;
    dw_d[0] = NB'(mag[HW:1]);
    dr_d[0] = 2'd0;
    for (int j = 1; j <= DIV_ST; j++) begin
      w = dw_q[j-1];
      r = dr_q[j-1];
      for (int i = 0; i < 4; i++) begin
        if ((j - 1) * 4 + i < NIB) begin
          st = div3_step(r, w[NB-1 -: 4]);
          w  = {w[NB-5:0], st[5:2]};
          r  = st[1:0];
        end
      end
      dw_d[j] = w;
      dr_d[j] = r;
    end
  end

  assign quot = dw_q[DIV_ST][P-1:0];
  assign qx   = signed'(DW'(quot));
  assign avg  = dneg_q[DIV_ST] ? -qx : qx;
  assign diff = DW'(cfg_i.target) - avg;

  always_comb begin
    priority if (diff > E_MAX) begin
      err_c = E_MAX[ERR_W-1:0];
    end else if (diff < E_MIN) begin
      err_c = E_MIN[ERR_W-1:0];
    end else begin
      err_c = diff[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tl_q <= TW'(left_front_pos_i) + TW'(left_mid_pos_i) + TW'(left_back_pos_i);
      tr_q <= TW'(right_front_pos_i) + TW'(right_mid_pos_i) + TW'(right_back_pos_i);
      rs1_q <= restart_i;
      dneg_q[0] <= sum6[SW-1];
      drs_q[0]  <= rs1_q;
      for (int j = 0; j <= DIV_ST; j++) begin
        dw_q[j] <= dw_d[j];
        dr_q[j] <= dr_d[j];
      end
      for (int j = 1; j <= DIV_ST; j++) begin
        dneg_q[j] <= dneg_q[j-1];
        drs_q[j]  <= drs_q[j-1];
      end
      word_q.restart <= drs_q[DIV_ST];
      word_q.err     <= err_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int j = 0; j <= DIV_ST; j++) begin
        dv_q[j] <= 1'b0;
      end
      wv_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      dv_q[0] <= v1_q;
      for (int j = 1; j <= DIV_ST; j++) begin
        dv_q[j] <= dv_q[j-1];
      end
      wv_q <= dv_q[DIV_ST];
    end
  end

endmodule

FILE: src/ddpl_queue.sv
// Short queue of error words between the front and back pipelines.
`timescale 1ns / 1ps

module ddpl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  ddpl_pkg::q_word_t push_word_i,
  input  logic              pop_i,
  output ddpl_pkg::q_word_t word_o,
  output ddpl_pkg::q_stat_t stat_o
);
  import ddpl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  q_word_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign push   = push_valid_i && !stat_o.full;
  assign pop    = pop_i && !stat_o.empty;
  assign word_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/ddpl_back.sv
// Back pipeline: integral, derivative and done state, gain products, drive clamp.
`timescale 1ns / 1ps

module ddpl_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ddpl_pkg::cfg_t                      cfg_i,
  input  ddpl_pkg::q_word_t                   word_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ddpl_pkg::CMD_W-1:0]   drive_command_o,
  output logic                                move_done_o
);
  import ddpl_pkg::*;

  localparam int IW = ERR_W + 1;
  localparam int PE = GAIN_W + ERR_W;
  localparam int PI = GAIN_W + INT_W;
  localparam int PD = GAIN_W + IW;
  localparam logic signed [ACC_W-1:0] A_MAX = ACC_W'(ACC_LIMIT);
  localparam logic signed [ACC_W-1:0] A_MIN = -A_MAX;

  logic                    en;
  logic signed [INT_W-1:0] int_q;
  logic signed [ERR_W-1:0] prev_q;
  logic                    fin_q;

  logic signed [INT_W-1:0] int0;
  logic signed [ERR_W-1:0] prev0;
  logic                    fin0;
  logic signed [IW-1:0]    isum, lim, emag;
  logic signed [INT_W-1:0] int_n;
  logic                    hit;

  logic signed [ERR_W-1:0] e1_q;
  logic signed [INT_W-1:0] i1_q;
  logic signed [IW-1:0]    d1_q;
  logic                    z1_q, dn1_q, v1_q;

  logic signed [PE-1:0]    pe_q;
  logic signed [PI-1:0]    pi_q;
  logic signed [PD-1:0]    pd_q;
  logic                    z2_q, dn2_q, v2_q;

  logic signed [ACC_W-1:0] acc, acc_c;
  logic signed [CMD_W-1:0] cmd_q;
  logic                    done_q, ov_q;

  assign en              = !ov_q || out_ready_i;
  assign pop_o           = en && !empty_i;
  assign out_valid_o     = ov_q;
  assign drive_command_o = cmd_q;
  assign move_done_o     = done_q;

  always_comb begin
    int0  = word_i.restart ? '0 : int_q;
    prev0 = word_i.restart ? '0 : prev_q;
    fin0  = word_i.restart ? 1'b0 : fin_q;
    isum  = IW'(int0) + IW'(word_i.err);
    lim   = signed'(IW'(cfg_i.int_limit));
    priority if (isum > lim) begin
      int_n = lim[INT_W-1:0];
    end else if (isum < -lim) begin
      int_n = INT_W'(-lim);
    end else begin
      int_n = isum[INT_W-1:0];
    end
    emag = word_i.err[ERR_W-1] ? -IW'(word_i.err) : IW'(word_i.err);
    hit  = (emag <= signed'(IW'(cfg_i.done_band)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q  <= '0;
      prev_q <= '0;
      fin_q  <= 1'b0;
    end else if (pop_o) begin
      int_q  <= fin0 ? int0 : int_n;
      prev_q <= fin0 ? prev0 : word_i.err;
      fin_q  <= fin0 || hit;
    end
  end

  assign acc = ACC_W'(pe_q) + ACC_W'(pi_q) + ACC_W'(pd_q);

  always_comb begin
    priority if (acc > A_MAX) begin
      acc_c = A_MAX;
    end else if (acc < A_MIN) begin
      acc_c = A_MIN;
    end else begin
      acc_c = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q   <= word_i.err;
      i1_q   <= int_n;
      d1_q   <= IW'(word_i.err) - IW'(prev0);
      z1_q   <= fin0;
      dn1_q  <= fin0 || hit;
      pe_q   <= PE'(cfg_i.gain_p) * PE'(e1_q);
      pi_q   <= PI'(cfg_i.gain_i) * PI'(i1_q);
      pd_q   <= PD'(cfg_i.gain_d) * PD'(d1_q);
      z2_q   <= z1_q;
      dn2_q  <= dn1_q;
      cmd_q  <= z2_q ? '0 : CMD_W'(acc_c >>> CMD_SHIFT);
      done_q <= dn2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      ov_q <= v2_q;
    end
  end

endmodule

FILE: src/drive_distance_pid_loop_unit.sv
// Throughput: one word per cycle unless stalled, set by the integral/done state update.
// The divide by six is a radix-16 digit pipeline, four digits a stage.
// Reset: asynchronous, clears registers to defaults, state, queue and valids at once.
// Top level: registers, front pipeline, word queue and back pipeline.
`timescale 1ns / 1ps

module drive_distance_pid_loop_unit #(
  parameter int POSITION_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ddpl_pkg::PADDR_W-1:0]       paddr,
  input  logic [ddpl_pkg::PDATA_W-1:0]       pwdata,
  output logic [ddpl_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               restart_i,
  input  logic signed [POSITION_BITS-1:0]    left_front_pos_i,
  input  logic signed [POSITION_BITS-1:0]    left_mid_pos_i,
  input  logic signed [POSITION_BITS-1:0]    left_back_pos_i,
  input  logic signed [POSITION_BITS-1:0]    right_front_pos_i,
  input  logic signed [POSITION_BITS-1:0]    right_mid_pos_i,
  input  logic signed [POSITION_BITS-1:0]    right_back_pos_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ddpl_pkg::CMD_W-1:0]  drive_command_o,
  output logic                               move_done_o
);
  import ddpl_pkg::*;

  cfg_t    cfg;
  q_word_t f_word, q_word;
  q_stat_t q_stat;
  logic    f_valid, q_pop;

  ddpl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ddpl_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .restart_i         (restart_i),
    .left_front_pos_i  (left_front_pos_i),
    .left_mid_pos_i    (left_mid_pos_i),
    .left_back_pos_i   (left_back_pos_i),
    .right_front_pos_i (right_front_pos_i),
    .right_mid_pos_i   (right_mid_pos_i),
    .right_back_pos_i  (right_back_pos_i),
    .word_valid_o      (f_valid),
    .word_o            (f_word),
    .full_i            (q_stat.full)
  );

  ddpl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_word_i  (f_word),
    .pop_i        (q_pop),
    .word_o       (q_word),
    .stat_o       (q_stat)
  );

  ddpl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .word_i          (q_word),
    .empty_i         (q_stat.empty),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_command_o (drive_command_o),
    .move_done_o     (move_done_o)
  );

  a_cmd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_command_o >= -15'sd12800 && drive_command_o <= 15'sd12800))
    else $error("drive command outside full power range");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (q_stat.full && f_valid))
    else $error("front stalled while queue had room");

  a_pop_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !out_valid_o) |=> !q_stat.full)
    else $error("queue full right after a pop into an empty back pipeline");

endmodule

FILE: tb/tb_top.sv
// Testbench for the drive distance PID loop: directed and random encoder words against a PID predictor.
`timescale 1ns / 1ps

module tb_top;
  import ddpl_pkg::*;

  localparam int     POS_W   = 24;
  localparam longint ERR_HI  = 64'sd16777215;
  localparam longint ERR_LO  = -64'sd16777216;
  localparam longint POS_HI  = 64'sd8388607;
  localparam longint POS_LO  = -64'sd8388608;
  localparam int     HOLD_LEN = 300;

  typedef struct packed {
    logic                    restart;
    logic signed [POS_W-1:0] lf, lm, lb, rf, rm, rb;
  } enc_word_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd;
    logic                    done;
  } drive_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      restart_i = 1'b0;
  logic signed [POS_W-1:0]   left_front_pos_i = '0;
  logic signed [POS_W-1:0]   left_mid_pos_i = '0;
  logic signed [POS_W-1:0]   left_back_pos_i = '0;
  logic signed [POS_W-1:0]   right_front_pos_i = '0;
  logic signed [POS_W-1:0]   right_mid_pos_i = '0;
  logic signed [POS_W-1:0]   right_back_pos_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [CMD_W-1:0]   drive_command_o;
  logic                      move_done_o;

  cfg_t            pid_cfg;
  longint          pid_integral;
  longint          pid_last_err;
  bit              move_finished;
  drive_result_t   pending_drive[$];
  drive_result_t   due_drive;
  int              error_count = 0;
  int              words_sent = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_req = 0;
  int              hold_seen = 0;
  int              hold_cnt = 0;

  drive_distance_pid_loop_unit #(.POSITION_BITS(POS_W)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .restart_i        (restart_i),
    .left_front_pos_i (left_front_pos_i),
    .left_mid_pos_i   (left_mid_pos_i),
    .left_back_pos_i  (left_back_pos_i),
    .right_front_pos_i(right_front_pos_i),
    .right_mid_pos_i  (right_mid_pos_i),
    .right_back_pos_i (right_back_pos_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_command_o  (drive_command_o),
    .move_done_o      (move_done_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint clamp64(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic logic signed [POS_W-1:0] clip_pos(input longint x);
    return POS_W'(clamp64(x, POS_LO, POS_HI));
  endfunction

  function automatic drive_result_t pid_predict(input enc_word_t w);
    longint        sum;
    longint        err;
    longint        lim;
    longint        deriv;
    longint        acc;
    longint        mag;
    drive_result_t r;
    if (w.restart) begin
      pid_integral  = 0;
      pid_last_err  = 0;
      move_finished = 1'b0;
    end
    if (move_finished) begin
      r.cmd  = '0;
      r.done = 1'b1;
      return r;
    end
    sum = longint'(w.lf) + longint'(w.lm) + longint'(w.lb)
        + longint'(w.rf) + longint'(w.rm) + longint'(w.rb);
    err = clamp64(longint'(pid_cfg.target) - sum / 6, ERR_LO, ERR_HI);
    lim = longint'(pid_cfg.int_limit);
    pid_integral = clamp64(pid_integral + err, -lim, lim);
    deriv = err - pid_last_err;
    pid_last_err = err;
    acc = longint'(pid_cfg.gain_p) * err + longint'(pid_cfg.gain_i) * pid_integral
        + longint'(pid_cfg.gain_d) * deriv;
    acc = clamp64(acc, -longint'(ACC_LIMIT), longint'(ACC_LIMIT));
    mag = (err < 0) ? -err : err;
    if (mag <= longint'(pid_cfg.done_band)) move_finished = 1'b1;
    r.cmd  = CMD_W'(acc >>> CMD_SHIFT);
    r.done = move_finished;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 100) begin
      $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_cnt    <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected drive word", drive_command_o, 0);
      end else begin
        due_drive = pending_drive.pop_front();
        if (drive_command_o !== due_drive.cmd) begin
          report_mismatch("drive_command", drive_command_o, due_drive.cmd);
        end
        if (move_done_o !== due_drive.done) begin
          report_mismatch("move_done", move_done_o, due_drive.done);
        end
      end
    end
  end

  task automatic send_word(input enc_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    restart_i         <= w.restart;
    left_front_pos_i  <= w.lf;
    left_mid_pos_i    <= w.lm;
    left_back_pos_i   <= w.lb;
    right_front_pos_i <= w.rf;
    right_mid_pos_i   <= w.rm;
    right_back_pos_i  <= w.rb;
    do @(posedge clk_i); while (!in_ready_o);
    pending_drive.push_back(pid_predict(w));
    words_sent++;
  endtask

  task automatic send_uniform(input logic rs, input logic signed [POS_W-1:0] p);
    enc_word_t w;
    w = '{restart: rs, lf: p, lm: p, lb: p, rf: p, rm: p, rb: p};
    send_word(w);
  endtask

  task automatic send_noise();
    enc_word_t w;
    w.restart = $urandom_range(1);
    w.lf = POS_W'($urandom());
    w.lm = POS_W'($urandom());
    w.lb = POS_W'($urandom());
    w.rf = POS_W'($urandom());
    w.rm = POS_W'($urandom());
    w.rb = POS_W'($urandom());
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask;
    case (idx)
      REG_TARGET: begin
        pid_cfg.target = value[TARGET_W-1:0];
        mask = PDATA_W'((64'd1 << TARGET_W) - 1);
      end
      REG_GAIN_P: begin
        pid_cfg.gain_p = value[GAIN_W-1:0];
        mask = PDATA_W'((64'd1 << GAIN_W) - 1);
      end
      REG_GAIN_I: begin
        pid_cfg.gain_i = value[GAIN_W-1:0];
        mask = PDATA_W'((64'd1 << GAIN_W) - 1);
      end
      REG_GAIN_D: begin
        pid_cfg.gain_d = value[GAIN_W-1:0];
        mask = PDATA_W'((64'd1 << GAIN_W) - 1);
      end
      REG_INT_LIM: begin
        pid_cfg.int_limit = value[LIMIT_W-1:0];
        mask = PDATA_W'((64'd1 << LIMIT_W) - 1);
      end
      default: begin
        pid_cfg.done_band = value[BAND_W-1:0];
        mask = PDATA_W'((64'd1 << BAND_W) - 1);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      report_mismatch("register read-back", prdata & mask, value & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(input logic signed [TARGET_W-1:0] t,
                         input logic signed [GAIN_W-1:0] gp, gi, gd,
                         input logic [LIMIT_W-1:0] lim, input logic [BAND_W-1:0] band);
    wait_idle();
    cfg_write(REG_TARGET, PDATA_W'(t));
    cfg_write(REG_GAIN_P, PDATA_W'(gp));
    cfg_write(REG_GAIN_I, PDATA_W'(gi));
    cfg_write(REG_GAIN_D, PDATA_W'(gd));
    cfg_write(REG_INT_LIM, PDATA_W'(lim));
    cfg_write(REG_DONE_BND, PDATA_W'(band));
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    if ($urandom_range(99) < 70) return GAIN_W'(int'($urandom_range(2048)) - 1024);
    return GAIN_W'($urandom());
  endfunction

  task automatic pick_settings(input int kind);
    logic signed [TARGET_W-1:0] t;
    logic [BAND_W-1:0]          band;
    case (kind)
      0: set_all(8388607, 32767, 32767, 32767, 2047, 4095);
      1: set_all(-8388608, -32768, -32768, -32768, 0, 0);
      default: begin
        if ($urandom_range(1)) t = TARGET_W'(int'($urandom_range(200000)) - 100000);
        else t = TARGET_W'($urandom());
        if ($urandom_range(99) < 70) band = BAND_W'($urandom_range(64));
        else band = BAND_W'($urandom());
        set_all(t, pick_gain(), pick_gain(), pick_gain(), LIMIT_W'($urandom_range(2047)), band);
      end
    endcase
  endtask

  task automatic run_move();
    enc_word_t w;
    longint    gap;
    longint    base;
    int        jitter;
    int        ticks;
    int        tail;
    gap    = longint'($urandom_range(40000));
    jitter = $urandom_range(8);
    ticks  = 0;
    if ($urandom_range(1)) gap = -gap;
    while ((ticks == 0 || !move_finished) && ticks < 40) begin
      base = longint'(pid_cfg.target) - gap;
      w.restart = (ticks == 0);
      w.lf = clip_pos(base + longint'($urandom_range(2 * jitter)) - jitter);
      w.lm = clip_pos(base + longint'($urandom_range(2 * jitter)) - jitter);
      w.lb = clip_pos(base + longint'($urandom_range(2 * jitter)) - jitter);
      w.rf = clip_pos(base + longint'($urandom_range(2 * jitter)) - jitter);
      w.rm = clip_pos(base + longint'($urandom_range(2 * jitter)) - jitter);
      w.rb = clip_pos(base + longint'($urandom_range(2 * jitter)) - jitter);
      send_word(w);
      ticks++;
      gap = gap * longint'($urandom_range(30, 90)) / 100;
      if (gap == 0) jitter = jitter / 2;
    end
    tail = $urandom_range(3);
    repeat (tail) begin
      w.restart = 1'b0;
      w.lf = POS_W'($urandom());
      w.lm = POS_W'($urandom());
      w.lb = POS_W'($urandom());
      w.rf = POS_W'($urandom());
      w.rm = POS_W'($urandom());
      w.rb = POS_W'($urandom());
      send_word(w);
    end
  endtask

  task automatic run_block(input int n);
    int start;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(99) < 15) send_noise();
      else run_move();
    end
  endtask

  task automatic test_register_access();
    set_all(24'sh5A5A5A, 16'sh7F01, -16'sd2, 16'sh00FF, 11'h555, 12'hAAA);
    set_all(-24'sd1, 16'sh8000, 16'sh7FFF, -16'sd256, 11'h7FF, 12'hFFF);
  endtask

  task automatic test_field_extremes();
    enc_word_t w;
    set_all(0, 256, 0, 128, 1600, 16);
    send_uniform(1'b1, 24'sh7FFFFF);
    send_uniform(1'b1, -24'sh800000);
    w = '{restart: 1'b1, lf: 24'sh7FFFFF, lm: -24'sh800000, lb: 24'sh7FFFFF,
          rf: -24'sh800000, rm: 24'sh7FFFFF, rb: -24'sh800000};
    send_word(w);
    send_uniform(1'b0, 24'sh7FFFFF);
    w = '{restart: 1'b1, lf: 100, lm: 100, lb: 100, rf: 100, rm: 100, rb: -7};
    send_word(w);
    w = '{restart: 1'b1, lf: -100, lm: -100, lb: -100, rf: -100, rm: -100, rb: 7};
    send_word(w);
  endtask

  task automatic test_done_and_finish();
    set_all(1000, 256, 64, 32, 1600, 16);
    send_uniform(1'b1, 0);
    send_uniform(1'b0, 500);
    send_uniform(1'b0, 990);
    send_uniform(1'b0, 0);
    send_uniform(1'b0, 24'sh7FFFFF);
    send_uniform(1'b1, 1000);
    send_uniform(1'b1, 984);
    send_uniform(1'b1, 983);
  endtask

  task automatic test_integral_clamp();
    set_all(3000, 0, 32767, 0, 0, 0);
    send_uniform(1'b1, 0);
    send_uniform(1'b0, 0);
    set_all(3000, 0, 32767, 0, 2047, 0);
    send_uniform(1'b1, 0);
    send_uniform(1'b0, 0);
    send_uniform(1'b0, 6000);
    send_uniform(1'b0, 6000);
  endtask

  task automatic test_power_saturation();
    enc_word_t w;
    set_all(8388607, 32767, 32767, 32767, 2047, 0);
    send_uniform(1'b1, -24'sh800000);
    send_uniform(1'b0, -24'sh800000);
    set_all(-8388608, -32768, -32768, -32768, 2047, 0);
    send_uniform(1'b1, 24'sh7FFFFF);
    w = '{restart: 1'b0, lf: -24'sh800000, lm: 24'sh7FFFFF, lb: 24'sh7FFFFF,
          rf: 24'sh7FFFFF, rm: 24'sh7FFFFF, rb: 24'sh7FFFFF};
    send_word(w);
  endtask

  task automatic test_random_traffic(input int sp, input int rp, input int n);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int k = 0; k < 5; k++) begin
      pick_settings(k);
      run_block(n / 5);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    repeat (40) send_noise();
    wait_idle();
  endtask

  initial begin
    pid_cfg = '{target: '0, gain_p: '0, gain_i: '0, gain_d: '0,
                int_limit: LIMIT_RESET, done_band: BAND_RESET};
    pid_integral  = 0;
    pid_last_err  = 0;
    move_finished = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_uniform(1'b0, 100);
    test_register_access();
    test_field_extremes();
    test_done_and_finish();
    test_integral_clamp();
    test_power_saturation();
    test_random_traffic(34, 61, 400);
    test_random_traffic(61, 34, 400);
    test_random_traffic(0, 0, 400);
    test_backpressure();
    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
src/ddpl_pkg.sv
src/ddpl_regs.sv
src/ddpl_front.sv
src/ddpl_queue.sv
src/ddpl_back.sv
src/drive_distance_pid_loop_unit.sv
tb/tb_top.sv
